// ===== src/text_token_lexer_top_assert.svh =====
// Assertion macros for the text token lexer.
// Used by text_token_lexer_top; expects clk and arst_n in scope.
`ifndef TEXT_TOKEN_LEXER_TOP_ASSERT_SVH
`define TEXT_TOKEN_LEXER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TTL_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("text token lexer check failed");

// The consequent must hold in the cycle after the antecedent.
`define TTL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("text token lexer check failed");

`endif

// ===== src/ttl_pkg.sv =====
// Package for the text token lexer: lexer modes, token classes, byte codes
// and byte classifiers. No dependencies.
`default_nettype none

package ttl_pkg;

	typedef enum logic [2:0] {
		MODE_IDLE     = 3'd0,
		MODE_WORD     = 3'd1,
		MODE_NUM      = 3'd2,
		MODE_STR      = 3'd3,
		MODE_STR_ESC  = 3'd4,
		MODE_CHR_OPEN = 3'd5,
		MODE_CHR_ESC  = 3'd6,
		MODE_CHR_SKIP = 3'd7
	} lex_mode_t;

	localparam logic [2:0] CLS_WORD   = 3'd0;
	localparam logic [2:0] CLS_CHAR   = 3'd1;
	localparam logic [2:0] CLS_STRING = 3'd2;
	localparam logic [2:0] CLS_INT    = 3'd3;
	localparam logic [2:0] CLS_FLOAT  = 3'd4;
	localparam logic [2:0] CLS_NUMBER = 3'd5;
	localparam logic [2:0] CLS_SYMBOL = 3'd6;

	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_APOS   = 8'h27;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_NL     = 8'h0A;

	// Most results that a single input byte can cause.
	localparam int MAX_RES = 3;

	typedef struct packed {
		logic [2:0] token_class;
		logic [7:0] value_byte;
		logic       byte_valid;
		logic       token_last;
	} lex_res_t;

	function automatic logic is_digit(input logic [7:0] b);
		is_digit = (b >= 8'h30) && (b <= 8'h39);
	endfunction

	function automatic logic is_letter(input logic [7:0] b);
		is_letter = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
	endfunction

	function automatic logic is_delim(input logic [7:0] b);
		is_delim = (b == CH_SPACE) || (b == CH_NL) || (b == CH_DOT) || (b == 8'h2C) ||
			(b == 8'h3B) || (b == 8'h3A) || (b == 8'h28) || (b == 8'h29) ||
			(b == 8'h5B) || (b == 8'h5D) || (b == 8'h7B) || (b == 8'h7D);
	endfunction

	function automatic lex_res_t mk_res(input logic [2:0] cls, input logic [7:0] b,
		input logic bv, input logic last);
		mk_res.token_class = cls;
		mk_res.value_byte  = bv ? b : 8'h00;
		mk_res.byte_valid  = bv;
		mk_res.token_last  = last;
	endfunction

endpackage

`default_nettype wire

// ===== src/ttl_in_if.sv =====
// Input channel of the text token lexer: one text byte and its end flag.
// No dependencies.
`default_nettype none

interface ttl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== src/ttl_out_if.sv =====
// Output channel of the text token lexer: one token word per handshake.
// No dependencies.
`default_nettype none

interface ttl_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] token_class;
	logic [7:0] value_byte;
	logic       byte_valid;
	logic       token_last;

	modport source (output valid, output token_class, output value_byte,
		output byte_valid, output token_last, input ready);
	modport sink (input valid, input token_class, input value_byte,
		input byte_valid, input token_last, output ready);
endinterface

`default_nettype wire

// ===== src/text_token_lexer_top.sv =====
// Streaming lexer: bytes in, tagged token words out, one word per cycle
// while the output is ready. A byte is registered, lexed in one pass into
// up to three words, and the words leave from a small result buffer. A byte
// that yields at most one word sustains one byte per cycle while the output
// is ready; a byte yielding two or three words (a delimiter after a word, a
// dot after a number) holds the input while the buffer drains. Depends on
// ttl_pkg, ttl_in_if, ttl_out_if and text_token_lexer_top_assert.svh.
`default_nettype none
`include "text_token_lexer_top_assert.svh"

module text_token_lexer_top
	import ttl_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cfg_wr_en,
	input  wire logic  cfg_wr_data,
	ttl_in_if.sink     in_ch,
	ttl_out_if.source  out_ch
);

	logic            ews_q;
	logic            valid_s1;
	logic [7:0]      byte_s1;
	logic            last_s1;

	lex_mode_t       mode_q, mode_d;
	logic [1:0]      dot_cnt_q, dot_cnt_d;
	logic            dot_pend_q, dot_pend_d;
	logic [2:0]      cls_q, cls_d;

	lex_res_t        res_q [MAX_RES];
	lex_res_t        res_d [MAX_RES];
	logic [1:0]      cnt_q, cnt_d;
	logic [1:0]      idx_q;

	logic            in_fire, out_fire, buf_free, load, do_start;

	assign out_fire = out_ch.valid && out_ch.ready;
	assign in_fire  = in_ch.valid && in_ch.ready;
	// The buffer is free when empty or when its final word leaves this cycle.
	assign buf_free = (cnt_q == 2'd0) || (out_fire && (idx_q == cnt_q - 2'd1));
	assign load     = valid_s1 && buf_free;
	assign in_ch.ready = !valid_s1 || load;

	assign out_ch.valid       = (cnt_q != 2'd0);
	assign out_ch.token_class = res_q[idx_q].token_class;
	assign out_ch.value_byte  = res_q[idx_q].value_byte;
	assign out_ch.byte_valid  = res_q[idx_q].byte_valid;
	assign out_ch.token_last  = res_q[idx_q].token_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ews_q <= 1'b0;
		end else if (cfg_wr_en) begin
			ews_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= in_ch.data_byte;
			last_s1 <= in_ch.last_byte;
		end
	end

	// One lexing pass over the registered byte.
	always_comb begin
		logic [1:0] n;
		logic [2:0] c;
		n          = 2'd0;
		c          = CLS_FLOAT;
		mode_d     = mode_q;
		dot_cnt_d  = dot_cnt_q;
		dot_pend_d = dot_pend_q;
		cls_d      = cls_q;
		do_start   = 1'b0;
		for (int i = 0; i < MAX_RES; i++) begin
			res_d[i] = mk_res(CLS_WORD, 8'h00, 1'b0, 1'b0);
		end

		case (mode_q)
			MODE_WORD: begin
				if (is_delim(byte_s1)) begin
					res_d[n] = mk_res(cls_q, 8'h00, 1'b0, 1'b1);
					n = n + 2'd1;
					do_start = 1'b1;
				end else begin
					res_d[n] = mk_res(CLS_WORD, byte_s1, 1'b1, last_s1);
					n = n + 2'd1;
					if (last_s1) begin
						mode_d = MODE_IDLE;
						dot_pend_d = 1'b0;
					end
				end
			end
			MODE_NUM: begin
				if (dot_pend_q) begin
					if (is_digit(byte_s1)) begin
						c = (dot_cnt_q == 2'd0) ? CLS_FLOAT : CLS_NUMBER;
						cls_d = c;
						if (dot_cnt_q != 2'd2) begin
							dot_cnt_d = dot_cnt_q + 2'd1;
						end
						dot_pend_d = 1'b0;
						res_d[n] = mk_res(c, CH_DOT, 1'b1, 1'b0);
						n = n + 2'd1;
						res_d[n] = mk_res(c, byte_s1, 1'b1, last_s1);
						n = n + 2'd1;
						if (last_s1) begin
							mode_d = MODE_IDLE;
						end
					end else begin
						res_d[n] = mk_res(cls_q, 8'h00, 1'b0, 1'b1);
						n = n + 2'd1;
						res_d[n] = mk_res(CLS_SYMBOL, CH_DOT, 1'b1, 1'b1);
						n = n + 2'd1;
						do_start = 1'b1;
					end
				end else if (is_digit(byte_s1)) begin
					res_d[n] = mk_res(cls_q, byte_s1, 1'b1, last_s1);
					n = n + 2'd1;
					if (last_s1) begin
						mode_d = MODE_IDLE;
					end
				end else if (byte_s1 == CH_DOT) begin
					if (last_s1) begin
						res_d[n] = mk_res(cls_q, 8'h00, 1'b0, 1'b1);
						n = n + 2'd1;
						res_d[n] = mk_res(CLS_SYMBOL, CH_DOT, 1'b1, 1'b1);
						n = n + 2'd1;
						cls_d = CLS_SYMBOL;
						mode_d = MODE_IDLE;
					end else begin
						dot_pend_d = 1'b1;
					end
				end else begin
					res_d[n] = mk_res(cls_q, 8'h00, 1'b0, 1'b1);
					n = n + 2'd1;
					do_start = 1'b1;
				end
			end
			MODE_STR: begin
				if (byte_s1 == CH_QUOTE) begin
					res_d[n] = mk_res(cls_q, 8'h00, 1'b0, 1'b1);
					n = n + 2'd1;
					mode_d = MODE_IDLE;
				end else if (byte_s1 == CH_BSLASH) begin
					if (last_s1) begin
						res_d[n] = mk_res(cls_q, 8'h00, 1'b0, 1'b1);
						n = n + 2'd1;
						mode_d = MODE_IDLE;
					end else begin
						mode_d = MODE_STR_ESC;
					end
				end else begin
					res_d[n] = mk_res(CLS_STRING, byte_s1, 1'b1, last_s1);
					n = n + 2'd1;
					if (last_s1) begin
						mode_d = MODE_IDLE;
					end
				end
			end
			MODE_STR_ESC: begin
				res_d[n] = mk_res(CLS_STRING, byte_s1, 1'b1, last_s1);
				n = n + 2'd1;
				mode_d = last_s1 ? MODE_IDLE : MODE_STR;
			end
			MODE_CHR_OPEN: begin
				if (byte_s1 == CH_APOS) begin
					res_d[n] = mk_res(cls_q, 8'h00, 1'b0, 1'b1);
					n = n + 2'd1;
					mode_d = MODE_IDLE;
				end else if (byte_s1 == CH_BSLASH) begin
					if (last_s1) begin
						res_d[n] = mk_res(cls_q, 8'h00, 1'b0, 1'b1);
						n = n + 2'd1;
						mode_d = MODE_IDLE;
					end else begin
						mode_d = MODE_CHR_ESC;
					end
				end else begin
					res_d[n] = mk_res(CLS_CHAR, byte_s1, 1'b1, 1'b1);
					n = n + 2'd1;
					mode_d = last_s1 ? MODE_IDLE : MODE_CHR_SKIP;
				end
			end
			MODE_CHR_ESC: begin
				res_d[n] = mk_res(CLS_CHAR, byte_s1, 1'b1, 1'b1);
				n = n + 2'd1;
				mode_d = last_s1 ? MODE_IDLE : MODE_CHR_SKIP;
			end
			MODE_CHR_SKIP: begin
				mode_d = MODE_IDLE;
			end
			default: begin
				do_start = 1'b1;
			end
		endcase

		// A byte seen between tokens; words already queued above keep
		// the class of the token they close.
		if (do_start) begin
			mode_d = MODE_IDLE;
			dot_pend_d = 1'b0;
			if (is_letter(byte_s1)) begin
				cls_d = CLS_WORD;
				res_d[n] = mk_res(CLS_WORD, byte_s1, 1'b1, last_s1);
				n = n + 2'd1;
				if (!last_s1) begin
					mode_d = MODE_WORD;
				end
			end else if (is_digit(byte_s1)) begin
				cls_d = CLS_INT;
				dot_cnt_d = 2'd0;
				res_d[n] = mk_res(CLS_INT, byte_s1, 1'b1, last_s1);
				n = n + 2'd1;
				if (!last_s1) begin
					mode_d = MODE_NUM;
				end
			end else if (byte_s1 == CH_QUOTE) begin
				cls_d = CLS_STRING;
				if (last_s1) begin
					res_d[n] = mk_res(CLS_STRING, 8'h00, 1'b0, 1'b1);
					n = n + 2'd1;
				end else begin
					mode_d = MODE_STR;
				end
			end else if (byte_s1 == CH_APOS) begin
				cls_d = CLS_CHAR;
				if (last_s1) begin
					res_d[n] = mk_res(CLS_CHAR, 8'h00, 1'b0, 1'b1);
					n = n + 2'd1;
				end else begin
					mode_d = MODE_CHR_OPEN;
				end
			end else if ((byte_s1 == CH_SPACE) || (byte_s1 == CH_TAB) ||
				(byte_s1 == CH_NL)) begin
				cls_d = CLS_SYMBOL;
				if (ews_q) begin
					res_d[n] = mk_res(CLS_SYMBOL, byte_s1, 1'b1, 1'b1);
					n = n + 2'd1;
				end
			end else begin
				cls_d = CLS_SYMBOL;
				res_d[n] = mk_res(CLS_SYMBOL, byte_s1, 1'b1, 1'b1);
				n = n + 2'd1;
			end
		end
		cnt_d = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_IDLE;
			dot_cnt_q  <= 2'd0;
			dot_pend_q <= 1'b0;
			cls_q      <= CLS_WORD;
		end else if (load) begin
			mode_q     <= mode_d;
			dot_cnt_q  <= dot_cnt_d;
			dot_pend_q <= dot_pend_d;
			cls_q      <= cls_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (load) begin
			cnt_q <= cnt_d;
			idx_q <= 2'd0;
		end else if (buf_free) begin
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (out_fire) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < MAX_RES; i++) begin
				res_q[i] <= res_d[i];
			end
		end
	end

	`TTL_ASSERT_NOW(a_idx_in_range, out_ch.valid, idx_q < cnt_q)
	`TTL_ASSERT_NOW(a_dot_only_in_num, dot_pend_q, mode_q == MODE_NUM)
	`TTL_ASSERT_NOW(a_dot_cnt_sat, 1'b1, dot_cnt_q != 2'd3)
	`TTL_ASSERT_NEXT(a_in_reg_filled, in_fire, valid_s1)

endmodule

`default_nettype wire
